[rtl/wpq_pkg.sv]
// shared types and constants of the waveform pulse qualifier
package wpq_pkg;

    // fixed field widths
    localparam int CHAN_W      = 6;
    localparam int GAIN_W      = 16;
    localparam int OVF_LEVEL_W = 13;
    localparam int THRESH_W    = 30;
    localparam int WIN_W       = 6;
    localparam int FRAC_W      = 16;
    localparam int FRAC_SHIFT  = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THRESH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_THRESHOLD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_WINDOW_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_WINDOW_STOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_FRACTION_LIMIT = 3'd4;

    // register reset values
    localparam logic [OVF_LEVEL_W-1:0]     OVF_LEVEL_RST  = 13'd4095;
    localparam logic signed [THRESH_W-1:0] THRESH_RST     = '0;
    localparam logic [WIN_W-1:0]           WIN_START_RST  = 6'd0;
    localparam logic [WIN_W-1:0]           WIN_STOP_RST   = 6'd63;
    localparam logic [FRAC_W-1:0]          FRAC_LIMIT_RST = 16'd4096;

    // control bits of one sample beat leaving the front end
    typedef struct packed {
        logic valid;
        logic last;
        logic over;
        logic inner;
    } t_front_ctl;

endpackage

[rtl/wpq_sample_front.sv]
// sample history, second difference and gain product for each sample beat
module wpq_sample_front #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 12,
    localparam int D_W    = SAMPLE_BITS + 2,
    localparam int PROD_W = D_W + wpq_pkg::GAIN_W + 1,
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1),
    localparam int IDX_W  = $clog2(MAX_SAMPLES)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_valid,
    input  logic [SAMPLE_BITS-1:0]           i_adc_sample,
    input  logic                             i_sample_last,
    input  logic [wpq_pkg::CHAN_W-1:0]       i_channel_index,
    input  logic [wpq_pkg::GAIN_W-1:0]       i_channel_gain,
    input  logic [wpq_pkg::OVF_LEVEL_W-1:0]  i_overflow_level,
    output wpq_pkg::t_front_ctl              o_ctl,
    output logic signed [D_W-1:0]            o_diff,
    output logic signed [PROD_W-1:0]         o_prod,
    output logic [IDX_W-1:0]                 o_idx,
    output logic [wpq_pkg::CHAN_W-1:0]       o_chan
);
    import wpq_pkg::*;

    localparam int LVL_W = (SAMPLE_BITS > OVF_LEVEL_W) ? SAMPLE_BITS : OVF_LEVEL_W;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] r_prev, r_older;
    logic [CNT_W-1:0]       r_count;
    logic signed [D_W-1:0]  n_diff;
    logic                   n_over;

    // stage a registers
    t_front_ctl             r_a_ctl;
    logic signed [D_W-1:0]  r_a_diff;
    logic [IDX_W-1:0]       r_a_idx;
    logic [CHAN_W-1:0]      r_a_chan;
    logic [GAIN_W-1:0]      r_a_gain;

    // stage b registers
    t_front_ctl             r_b_ctl;
    logic signed [D_W-1:0]  r_b_diff;
    logic signed [PROD_W-1:0] r_b_prod;
    logic [IDX_W-1:0]       r_b_idx;
    logic [CHAN_W-1:0]      r_b_chan;

    assign accept = i_valid && i_adv;

    // second difference against the two held samples, overflow compare
    always_comb begin
        n_diff = $signed(D_W'(i_adc_sample)) - $signed(D_W'({r_prev, 1'b0}))
                 + $signed(D_W'(r_older));
        n_over = LVL_W'(i_adc_sample) >= LVL_W'(i_overflow_level);
    end

    // sample history and index counter, cleared after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_older <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_sample_last) begin
                r_prev  <= '0;
                r_older <= '0;
                r_count <= '0;
            end else begin
                r_prev  <= i_adc_sample;
                r_older <= r_prev;
                if (r_count < CNT_W'(MAX_SAMPLES)) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // stage a: difference registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_adv) begin
            r_a_ctl.valid <= i_valid;
            r_a_ctl.last  <= i_sample_last;
            r_a_ctl.over  <= n_over;
            r_a_ctl.inner <= r_count >= CNT_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_diff <= n_diff;
            r_a_idx  <= IDX_W'(r_count - 1'b1);
            r_a_chan <= i_channel_index;
            r_a_gain <= i_channel_gain;
        end
    end

    // stage b: gain product registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_adv) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_diff <= r_a_diff;
            r_b_prod <= PROD_W'(r_a_diff) * PROD_W'($signed({1'b0, r_a_gain}));
            r_b_idx  <= r_a_idx;
            r_b_chan <= r_a_chan;
        end
    end

    assign o_ctl  = r_b_ctl;
    assign o_diff = r_b_diff;
    assign o_prod = r_b_prod;
    assign o_idx  = r_b_idx;
    assign o_chan = r_b_chan;

endmodule

[rtl/waveform_pulse_qualifier_top.sv]
// top level of the waveform pulse qualifier: dip tracking and result stage
//
// One ADC sample is taken every clock cycle while o_in_ready is high; the beat
// marked last produces one status result on o_out_valid through four register
// stages, the first loaded at the accepting edge: history and difference, gain
// multiply, dip tracking and summary, fraction test into the output register.
// The only thing that lowers o_in_ready is a result held in the output register
// with a second finished result queued behind it in the summary register while
// i_out_ready is low. The dip loop, one compare per region against the deepest
// dip so far, is combinational back into the tracking registers, which is
// what lets a sample follow its predecessor in the next cycle. Configuration
// writes are always accepted and must only be issued while the block is idle.
module waveform_pulse_qualifier_top #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [SAMPLE_BITS-1:0]          i_adc_sample,
    input  logic                            i_sample_last,
    input  logic [wpq_pkg::CHAN_W-1:0]      i_channel_index,
    input  logic [wpq_pkg::GAIN_W-1:0]      i_channel_gain,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [wpq_pkg::CHAN_W-1:0]      o_result_channel,
    output logic                            o_overflow_flag,
    output logic                            o_pre_pulse_flag,
    output logic                            o_post_pulse_flag,
    output logic                            o_no_pulse_flag,
    output logic                            o_pulse_valid,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wpq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wpq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wpq_pkg::*;

    localparam int D_W    = SAMPLE_BITS + 2;
    localparam int PROD_W = D_W + GAIN_W + 1;
    localparam int CMP_W  = (PROD_W > THRESH_W) ? PROD_W : THRESH_W;
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int IW     = (IDX_W > WIN_W) ? IDX_W : WIN_W;
    localparam int RAT_W  = D_W + FRAC_W + 1;

    // configuration registers
    logic [OVF_LEVEL_W-1:0]     r_ovf_level;
    logic signed [THRESH_W-1:0] r_thresh;
    logic [WIN_W-1:0]           r_win_start;
    logic [WIN_W-1:0]           r_win_stop;
    logic [FRAC_W-1:0]          r_frac_limit;

    logic adv;

    // front end outputs
    t_front_ctl               f_ctl;
    logic signed [D_W-1:0]    f_diff;
    logic signed [PROD_W-1:0] f_prod;
    logic [IDX_W-1:0]         f_idx;
    logic [CHAN_W-1:0]        f_chan;

    // dip tracking state
    logic signed [D_W-1:0] r_pre, r_good, r_post;
    logic                  r_ovf_seen;
    logic signed [D_W-1:0] n_pre, n_good, n_post;
    logic                  n_ovf;
    logic                  is_dip;
    logic [IW-1:0]         s_x, st_x, sp_x;

    // summary register
    logic                  r_s_valid;
    logic signed [D_W-1:0] r_s_pre, r_s_good, r_s_post;
    logic                  r_s_ovf;
    logic [CHAN_W-1:0]     r_s_chan;

    // result stage
    logic signed [RAT_W-1:0] lhs, rhs;
    logic n_pre_f, n_post_f, n_none_f, n_valid_f, good_f;
    logic r_out_valid;
    logic [CHAN_W-1:0] r_out_chan;
    logic r_out_ovf, r_out_pre, r_out_post, r_out_none, r_out_pv;

    // configuration write decode
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_level  <= OVF_LEVEL_RST;
            r_thresh     <= THRESH_RST;
            r_win_start  <= WIN_START_RST;
            r_win_stop   <= WIN_STOP_RST;
            r_frac_limit <= FRAC_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OVERFLOW_LEVEL:      r_ovf_level  <= i_cfg_data[OVF_LEVEL_W-1:0];
                CFG_DIP_THRESHOLD:       r_thresh     <= $signed(i_cfg_data[THRESH_W-1:0]);
                CFG_GOOD_WINDOW_START:   r_win_start  <= i_cfg_data[WIN_W-1:0];
                CFG_GOOD_WINDOW_STOP:    r_win_stop   <= i_cfg_data[WIN_W-1:0];
                CFG_POST_FRACTION_LIMIT: r_frac_limit <= i_cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the summary is stuck behind a full output
    assign adv        = !r_s_valid || !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    wpq_sample_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_valid          (i_in_valid),
        .i_adc_sample     (i_adc_sample),
        .i_sample_last    (i_sample_last),
        .i_channel_index  (i_channel_index),
        .i_channel_gain   (i_channel_gain),
        .i_overflow_level (r_ovf_level),
        .o_ctl            (f_ctl),
        .o_diff           (f_diff),
        .o_prod           (f_prod),
        .o_idx            (f_idx),
        .o_chan           (f_chan)
    );

    // region choice and deepest dip per region
    always_comb begin
        s_x    = IW'(f_idx);
        st_x   = IW'(r_win_start);
        sp_x   = IW'(r_win_stop);
        is_dip = f_ctl.inner && (CMP_W'(f_prod) <= CMP_W'(r_thresh));
        n_pre  = r_pre;
        n_good = r_good;
        n_post = r_post;
        n_ovf  = r_ovf_seen || f_ctl.over;
        if (is_dip) begin
            if (s_x < st_x && f_diff < r_pre) begin
                n_pre = f_diff;
            end else if (s_x >= st_x && s_x <= sp_x && f_diff < r_good) begin
                n_good = f_diff;
            end else if (s_x > sp_x && f_diff < r_post) begin
                n_post = f_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre      <= '0;
            r_good     <= '0;
            r_post     <= '0;
            r_ovf_seen <= 1'b0;
            r_s_valid  <= 1'b0;
        end else if (adv) begin
            r_s_valid <= f_ctl.valid && f_ctl.last;
            if (f_ctl.valid) begin
                if (f_ctl.last) begin
                    r_pre      <= '0;
                    r_good     <= '0;
                    r_post     <= '0;
                    r_ovf_seen <= 1'b0;
                end else begin
                    r_pre      <= n_pre;
                    r_good     <= n_good;
                    r_post     <= n_post;
                    r_ovf_seen <= n_ovf;
                end
            end
        end
    end

    // summary of a finished waveform
    always_ff @(posedge i_clk) begin
        if (adv && f_ctl.valid && f_ctl.last) begin
            r_s_pre  <= n_pre;
            r_s_good <= n_good;
            r_s_post <= n_post;
            r_s_ovf  <= n_ovf;
            r_s_chan <= f_chan;
        end
    end

    // post dip fraction test and final flags
    always_comb begin
        lhs      = RAT_W'(r_s_post) <<< FRAC_SHIFT;
        rhs      = RAT_W'($signed({1'b0, r_frac_limit})) * RAT_W'(r_s_good);
        good_f   = r_s_good != '0;
        n_pre_f  = !r_s_ovf && (r_s_pre != '0);
        n_post_f = !r_s_ovf && (r_s_post != '0) && !(good_f && lhs >= rhs);
        n_none_f = !r_s_ovf && !n_pre_f && !good_f && !n_post_f;
        n_valid_f = !r_s_ovf && !n_pre_f && !n_post_f && good_f;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s_valid && adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid && adv) begin
            r_out_chan <= r_s_chan;
            r_out_ovf  <= r_s_ovf;
            r_out_pre  <= n_pre_f;
            r_out_post <= n_post_f;
            r_out_none <= n_none_f;
            r_out_pv   <= n_valid_f;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_channel  = r_out_chan;
    assign o_overflow_flag   = r_out_ovf;
    assign o_pre_pulse_flag  = r_out_pre;
    assign o_post_pulse_flag = r_out_post;
    assign o_no_pulse_flag   = r_out_none;
    assign o_pulse_valid     = r_out_pv;

`ifndef SYNTHESIS
    // kept dips are never positive
    a_depth_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pre <= 0) && (r_good <= 0) && (r_post <= 0))
        else $error("kept dip depth became positive");

    // tracking state starts clean after a last beat
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && f_ctl.valid && f_ctl.last) |=>
        (r_pre == 0 && r_good == 0 && r_post == 0 && !r_ovf_seen))
        else $error("dip state not cleared after last beat");

    // input stalls only behind a full output and a queued summary
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && r_s_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    // overflow suppresses every pulse flag
    a_ovf_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_flag) |->
        !(o_pre_pulse_flag || o_post_pulse_flag || o_no_pulse_flag || o_pulse_valid))
        else $error("pulse flag set on overflowed waveform");

    // valid pulse excludes every other flag
    a_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pulse_valid) |->
        !(o_pre_pulse_flag || o_post_pulse_flag || o_no_pulse_flag))
        else $error("pulse valid together with another flag");
`endif

endmodule
